// ===== src/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants of the I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	localparam int BITS_PER_BYTE         = 8;
	localparam int PHASE_COUNT_WIDTH_DEF = 16;
	localparam int PHASE_TICKS_WIDTH     = 16;
	localparam int ACK_TIMEOUT_WIDTH     = 8;
	localparam int CFG_INDEX_WIDTH       = 2;
	localparam int CFG_DATA_WIDTH        = 16;

	localparam logic [PHASE_TICKS_WIDTH-1:0] PHASE_TICKS_RESET = 16'd1;
	localparam logic [ACK_TIMEOUT_WIDTH-1:0] ACK_TIMEOUT_RESET = 8'd250;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_PHASE_TICKS = 2'd0,
		CFG_ACK_TIMEOUT = 2'd1
	} cfg_index_t;

	typedef enum logic [2:0] {
		MODE_START     = 3'd0,
		MODE_STOP      = 3'd1,
		MODE_WRITE     = 3'd2,
		MODE_READ      = 3'd3,
		MODE_WAIT_ACK  = 3'd4,
		MODE_PULSE     = 3'd5,
		MODE_SEND_ACK  = 3'd6,
		MODE_SEND_NACK = 3'd7
	} mode_t;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'd0,
		ST_STA0    = 5'd1,
		ST_STA1    = 5'd2,
		ST_STA2    = 5'd3,
		ST_STA3    = 5'd4,
		ST_STO0    = 5'd5,
		ST_STO1    = 5'd6,
		ST_STO2    = 5'd7,
		ST_STO3    = 5'd8,
		ST_WR_INIT = 5'd9,
		ST_WR_DATA = 5'd10,
		ST_WR_HI   = 5'd11,
		ST_WR_LO   = 5'd12,
		ST_RD_REL  = 5'd13,
		ST_RD_LO   = 5'd14,
		ST_RD_HI   = 5'd15,
		ST_AK_LO   = 5'd16,
		ST_AK_SET  = 5'd17,
		ST_AK_HI   = 5'd18,
		ST_AK_END  = 5'd19,
		ST_WA_REL  = 5'd20,
		ST_WA_HI   = 5'd21,
		ST_WA_POLL = 5'd22,
		ST_WA_LO   = 5'd23,
		ST_PU_HI   = 5'd24,
		ST_PU_LO   = 5'd25
	} seq_state_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_drive;
		logic       sda_level;
		logic       busy;
		logic       done;
		logic [7:0] rx_byte;
		logic       ack_error;
	} seq_res_t;

endpackage

// ===== src/i2c_master_bit_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_unit
// Byte-level I2C master driven by bus ticks, one result per accepted tick.
// ----------------------------------------------------------------------------
// The result of a tick is registered and valid in the cycle after the tick transfer.
// Throughput: one tick per cycle while in_stall is low.
// in_stall rises only while a result waits and out_stall is high.
// Reset: sequencer idle with SCL high and SDA released, phase_ticks 1,
// ack_timeout 250, no result pending; the registered pin outputs are not reset.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit import i2cms_pkg::*; #(
	parameter int PHASE_COUNT_WIDTH = PHASE_COUNT_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       cmd_valid,
	input  logic [2:0]                 mode,
	input  logic [7:0]                 tx_byte,
	input  logic                       ack_after_read,
	input  logic                       sda_sampled,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       scl_level,
	output logic                       sda_drive,
	output logic                       sda_level,
	output logic                       busy_res,
	output logic                       done_res,
	output logic [7:0]                 rx_byte,
	output logic                       ack_error,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

	logic                         step;
	logic                         out_valid_q;
	seq_res_t                     res, res_q;
	logic [PHASE_TICKS_WIDTH-1:0] phase_ticks_q;
	logic [ACK_TIMEOUT_WIDTH-1:0] ack_timeout_q;

	assign in_stall  = out_valid_q & out_stall;
	assign step      = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RESET;
			ack_timeout_q <= ACK_TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PHASE_TICKS: phase_ticks_q <= cfg_data[PHASE_TICKS_WIDTH-1:0];
				CFG_ACK_TIMEOUT: ack_timeout_q <= cfg_data[ACK_TIMEOUT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	i2cms_seq #(
		.PHASE_COUNT_WIDTH(PHASE_COUNT_WIDTH)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.cmd_valid     (cmd_valid),
		.mode          (mode),
		.tx_byte       (tx_byte),
		.ack_after_read(ack_after_read),
		.sda_sampled   (sda_sampled),
		.phase_ticks   (phase_ticks_q),
		.ack_timeout   (ack_timeout_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = res_q.scl_level;
	assign sda_drive = res_q.sda_drive;
	assign sda_level = res_q.sda_level;
	assign busy_res  = res_q.busy;
	assign done_res  = res_q.done;
	assign rx_byte   = res_q.rx_byte;
	assign ack_error = res_q.ack_error;

endmodule

// ===== src/i2cms_seq.sv =====
// ----------------------------------------------------------------------------
// i2cms_seq
// Tick-driven pin sequencer: state, counters and pins, one tick per step.
// ----------------------------------------------------------------------------
module i2cms_seq import i2cms_pkg::*; #(
	parameter int PHASE_COUNT_WIDTH = PHASE_COUNT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         cmd_valid,
	input  logic [2:0]                   mode,
	input  logic [7:0]                   tx_byte,
	input  logic                         ack_after_read,
	input  logic                         sda_sampled,
	input  logic [PHASE_TICKS_WIDTH-1:0] phase_ticks,
	input  logic [ACK_TIMEOUT_WIDTH-1:0] ack_timeout,
	output seq_res_t                     res
);

	seq_state_t                   state_q, state_n, tgt;
	logic [3:0]                   bit_q, bit_n, bit_inc;
	logic [7:0]                   shift_q, shift_n;
	logic [7:0]                   poll_q, poll_n;
	logic [PHASE_COUNT_WIDTH-1:0] phase_q, phase_n, reload;
	logic                         scl_q, scl_n;
	logic                         drv_q, drv_n;
	logic                         sda_q, sda_n;
	logic                         err_q, err_n;
	logic [7:0]                   rx_q, rx_n;
	logic                         nack_q, nack_n;
	logic                         ent, done;
	logic [PHASE_TICKS_WIDTH-1:0] len_full;

	assign len_full = (phase_ticks == '0) ? '0 : phase_ticks - PHASE_TICKS_WIDTH'(1);

	generate
		if (PHASE_COUNT_WIDTH >= PHASE_TICKS_WIDTH) begin : g_wide
			assign reload = PHASE_COUNT_WIDTH'(len_full);
		end else begin : g_sat
			assign reload = (|len_full[PHASE_TICKS_WIDTH-1:PHASE_COUNT_WIDTH]) ?
				'1 : len_full[PHASE_COUNT_WIDTH-1:0];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			poll_q  <= '0;
			phase_q <= '0;
			scl_q   <= 1'b1;
			drv_q   <= 1'b0;
			sda_q   <= 1'b1;
			err_q   <= 1'b0;
			rx_q    <= '0;
			nack_q  <= 1'b0;
		end else if (step) begin
			state_q <= state_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			poll_q  <= poll_n;
			phase_q <= phase_n;
			scl_q   <= scl_n;
			drv_q   <= drv_n;
			sda_q   <= sda_n;
			err_q   <= err_n;
			rx_q    <= rx_n;
			nack_q  <= nack_n;
		end
	end

	always_comb begin
		state_n = state_q;
		bit_n   = bit_q;
		shift_n = shift_q;
		poll_n  = poll_q;
		phase_n = phase_q;
		scl_n   = scl_q;
		drv_n   = drv_q;
		sda_n   = sda_q;
		err_n   = err_q;
		rx_n    = rx_q;
		nack_n  = nack_q;
		ent     = 1'b0;
		done    = 1'b0;
		tgt     = ST_IDLE;
		bit_inc = bit_q + 4'd1;

		if (state_q == ST_IDLE) begin
			if (cmd_valid) begin
				err_n  = 1'b0;
				bit_n  = '0;
				poll_n = '0;
				ent    = 1'b1;
				unique case (mode_t'(mode))
					MODE_START: tgt = ST_STA0;
					MODE_STOP: tgt = ST_STO0;
					MODE_WRITE: begin
						shift_n = tx_byte;
						tgt     = ST_WR_INIT;
					end
					MODE_READ: begin
						shift_n = '0;
						nack_n  = ~ack_after_read;
						tgt     = ST_RD_REL;
					end
					MODE_WAIT_ACK: tgt = ST_WA_REL;
					MODE_PULSE: tgt = ST_PU_HI;
					MODE_SEND_ACK: begin
						nack_n = 1'b0;
						tgt    = ST_AK_LO;
					end
					MODE_SEND_NACK: begin
						nack_n = 1'b1;
						tgt    = ST_AK_LO;
					end
				endcase
			end
		end else if (state_q == ST_WA_POLL) begin
			if (!sda_sampled) begin
				ent = 1'b1;
				tgt = ST_WA_LO;
			end else if (poll_q >= ack_timeout) begin
				err_n = 1'b1;
				ent   = 1'b1;
				tgt   = ST_STO0;
			end else begin
				poll_n = poll_q + 8'd1;
			end
		end else if (phase_q != '0) begin
			phase_n = phase_q - PHASE_COUNT_WIDTH'(1);
		end else begin
			ent = 1'b1;
			unique case (state_q)
				ST_STA0: tgt = ST_STA1;
				ST_STA1: tgt = ST_STA2;
				ST_STA2: tgt = ST_STA3;
				ST_STO0: tgt = ST_STO1;
				ST_STO1: tgt = ST_STO2;
				ST_STO2: tgt = ST_STO3;
				ST_WR_INIT: tgt = ST_WR_DATA;
				ST_WR_DATA: tgt = ST_WR_HI;
				ST_WR_HI: tgt = ST_WR_LO;
				ST_WR_LO: begin
					bit_n = bit_inc;
					if (bit_inc < 4'(BITS_PER_BYTE)) begin
						tgt = ST_WR_DATA;
					end else begin
						ent  = 1'b0;
						done = 1'b1;
					end
				end
				ST_RD_REL: tgt = ST_RD_LO;
				ST_RD_LO: tgt = ST_RD_HI;
				ST_RD_HI: begin
					shift_n = {shift_q[6:0], sda_sampled};
					bit_n   = bit_inc;
					if (bit_inc < 4'(BITS_PER_BYTE)) begin
						tgt = ST_RD_LO;
					end else begin
						rx_n = shift_n;
						tgt  = ST_AK_LO;
					end
				end
				ST_AK_LO: tgt = ST_AK_SET;
				ST_AK_SET: tgt = ST_AK_HI;
				ST_AK_HI: tgt = ST_AK_END;
				ST_WA_REL: tgt = ST_WA_HI;
				ST_WA_HI: tgt = ST_WA_POLL;
				ST_PU_HI: tgt = ST_PU_LO;
				default: begin
					ent  = 1'b0;
					done = 1'b1;
				end
			endcase
			if (done) begin
				state_n = ST_IDLE;
			end
		end

		if (ent) begin
			state_n = tgt;
			phase_n = reload;
			unique case (tgt)
				ST_STA0: begin
					drv_n = 1'b1;
					sda_n = 1'b1;
				end
				ST_STA1, ST_STO2, ST_WR_HI, ST_RD_HI, ST_AK_HI, ST_WA_HI, ST_PU_HI: begin
					scl_n = 1'b1;
				end
				ST_STA2, ST_STO1: sda_n = 1'b0;
				ST_STO0, ST_WR_INIT: begin
					drv_n = 1'b1;
					scl_n = 1'b0;
				end
				ST_STO3: sda_n = 1'b1;
				ST_WR_DATA: begin
					sda_n   = shift_n[7];
					shift_n = {shift_n[6:0], 1'b0};
				end
				ST_RD_REL, ST_WA_REL: begin
					drv_n = 1'b0;
					sda_n = 1'b1;
				end
				ST_AK_SET: begin
					drv_n = 1'b1;
					sda_n = nack_n;
				end
				ST_STA3, ST_WR_LO, ST_RD_LO, ST_AK_LO, ST_AK_END, ST_WA_LO, ST_PU_LO: begin
					scl_n = 1'b0;
				end
				default: ;
			endcase
		end

		res.scl_level = scl_n;
		res.sda_drive = drv_n;
		res.sda_level = drv_n ? sda_n : 1'b1;
		res.busy      = (state_n != ST_IDLE);
		res.done      = done;
		res.rx_byte   = rx_n;
		res.ack_error = err_n;
	end

endmodule
